// ----- rtl/tts_pkg.sv -----
// Shared types and constants for the time-triggered task scheduler.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tts_pkg;

  // Table geometry
  localparam int MAX_TASKS    = 16;
  localparam int TIMEOUT_BITS = 16;
  localparam int RECUR_BITS   = 16;
  localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W        = $clog2(MAX_TASKS + 1);

  // Channel field widths
  localparam int OPCODE_W = 2;
  localparam int ID_W     = 4;
  localparam int KIND_W   = 3;
  localparam int IN_TMO_W = 16;
  localparam int IN_REC_W = 16;

  // Index compare width covers both the input index and the task count
  localparam int IDXCMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

  // Cap on fired items per tick
  localparam int OUT_MAX = 16;
  localparam int FIRE_W  = $clog2(OUT_MAX + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 2'd0,
    OP_REG  = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED      = 3'd0,
    KIND_NONE       = 3'd1,
    KIND_REGISTERED = 3'd2,
    KIND_FULL       = 3'd3,
    KIND_SET        = 3'd4,
    KIND_BAD        = 3'd5
  } kind_t;

  // One task table entry
  typedef struct packed {
    logic                    en;
    logic [RECUR_BITS-1:0]   period;
    logic [RECUR_BITS-1:0]   count;
    logic [TIMEOUT_BITS-1:0] timeout;
  } task_word_t;

  localparam int WORD_W = $bits(task_word_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_END,
    ST_SET_WR,
    ST_REPLY
  } state_t;

  typedef enum logic [1:0] {
    ADDR_SCAN,
    ADDR_IDX,
    ADDR_COUNT
  } addr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    addr_sel_t addr_sel;
    logic      ram_rd;
    logic      tick_start;
    logic      tick_eval;
    logic      scan_inc;
    logic      reg_write;
    logic      set_write;
    logic      set_reply;
    kind_t     reply_kind;
    logic      push_reply;
    logic      push_end;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_ok;
    logic count_zero;
    logic scan_last;
    logic ev_stall;
    logic slot_free;
  } dp_stat_t;

endpackage

// ----- rtl/tts_in_if.sv -----
// Input channel of the task scheduler: valid/ready handshake plus request fields.
// Depends on tts_pkg for field widths.
`timescale 1ns / 1ps

interface tts_in_if;
  logic                          valid;
  logic                          ready;
  logic [tts_pkg::OPCODE_W-1:0]  opcode;
  logic [tts_pkg::ID_W-1:0]      task_index;
  logic [tts_pkg::IN_TMO_W-1:0]  new_timeout;
  logic [tts_pkg::IN_REC_W-1:0]  recurrence;
  logic                          enabled;

  modport source (
    output valid, opcode, task_index, new_timeout, recurrence, enabled,
    input  ready
  );

  modport sink (
    input  valid, opcode, task_index, new_timeout, recurrence, enabled,
    output ready
  );
endinterface

// ----- rtl/tts_out_if.sv -----
// Result channel of the task scheduler: valid/ready handshake plus result fields.
// Depends on tts_pkg for field widths.
`timescale 1ns / 1ps

interface tts_out_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::KIND_W-1:0]  kind;
  logic [tts_pkg::ID_W-1:0]    task_id;
  logic                        last;

  modport source (
    output valid, kind, task_id, last,
    input  ready
  );

  modport sink (
    input  valid, kind, task_id, last,
    output ready
  );
endinterface

// ----- rtl/tts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tts_ctrl.sv -----
// Sequencing controller for the task scheduler.
// Depends on tts_pkg; drives command struct to tts_dp and reads its status.
`timescale 1ns / 1ps

module tts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tts_pkg::dp_stat_t stat,
  output tts_pkg::ctl_cmd_t cmd
);

  tts_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tts_pkg::ST_IDLE: begin
        // take no item while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_in = 1'b1;
          state_nxt   = tts_pkg::ST_DECODE;
        end
      end
      tts_pkg::ST_DECODE: begin
        case (stat.op)
          tts_pkg::OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_nxt = stat.count_zero ? tts_pkg::ST_TICK_END : tts_pkg::ST_TICK_RD;
          end
          tts_pkg::OP_REG: begin
            cmd.addr_sel  = tts_pkg::ADDR_COUNT;
            cmd.set_reply = 1'b1;
            if (stat.full) begin
              cmd.reply_kind = tts_pkg::KIND_FULL;
            end else begin
              cmd.reg_write  = 1'b1;
              cmd.reply_kind = tts_pkg::KIND_REGISTERED;
            end
            state_nxt = tts_pkg::ST_REPLY;
          end
          tts_pkg::OP_SET: begin
            cmd.addr_sel = tts_pkg::ADDR_IDX;
            if (stat.idx_ok) begin
              cmd.ram_rd = 1'b1;
              state_nxt  = tts_pkg::ST_SET_WR;
            end else begin
              cmd.set_reply  = 1'b1;
              cmd.reply_kind = tts_pkg::KIND_BAD;
              state_nxt      = tts_pkg::ST_REPLY;
            end
          end
          default: begin
            // unused opcode: drop silently
            state_nxt = tts_pkg::ST_IDLE;
          end
        endcase
      end
      tts_pkg::ST_TICK_RD: begin
        cmd.addr_sel = tts_pkg::ADDR_SCAN;
        cmd.ram_rd   = 1'b1;
        state_nxt    = tts_pkg::ST_TICK_EV;
      end
      tts_pkg::ST_TICK_EV: begin
        cmd.addr_sel = tts_pkg::ADDR_SCAN;
        if (!stat.ev_stall) begin
          cmd.tick_eval = 1'b1;
          if (stat.scan_last) begin
            state_nxt = tts_pkg::ST_TICK_END;
          end else begin
            cmd.scan_inc = 1'b1;
            state_nxt    = tts_pkg::ST_TICK_RD;
          end
        end
      end
      tts_pkg::ST_TICK_END: begin
        if (stat.slot_free) begin
          cmd.push_end = 1'b1;
          state_nxt    = tts_pkg::ST_IDLE;
        end
      end
      tts_pkg::ST_SET_WR: begin
        cmd.addr_sel   = tts_pkg::ADDR_IDX;
        cmd.set_write  = 1'b1;
        cmd.set_reply  = 1'b1;
        cmd.reply_kind = tts_pkg::KIND_SET;
        state_nxt      = tts_pkg::ST_REPLY;
      end
      tts_pkg::ST_REPLY: begin
        if (stat.slot_free) begin
          cmd.push_reply = 1'b1;
          state_nxt      = tts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tts_dp.sv -----
// Datapath of the task scheduler: request latch, task table RAM, tick evaluation,
// held fired item and output register. Depends on tts_pkg and tts_ram.
`timescale 1ns / 1ps

module tts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tts_pkg::ctl_cmd_t             cmd,
  output tts_pkg::dp_stat_t             stat,
  input  logic [tts_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [tts_pkg::ID_W-1:0]      in_task_index,
  input  logic [tts_pkg::IN_TMO_W-1:0]  in_new_timeout,
  input  logic [tts_pkg::IN_REC_W-1:0]  in_recurrence,
  input  logic                          in_enabled,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tts_pkg::KIND_W-1:0]    out_kind,
  output logic [tts_pkg::ID_W-1:0]      out_task_id,
  output logic                          out_last
);

  // Latched request
  tts_pkg::op_t                     op_r;
  logic [tts_pkg::ID_W-1:0]         idx_r;
  logic [tts_pkg::TIMEOUT_BITS-1:0] tmo_r;
  logic [tts_pkg::RECUR_BITS-1:0]   rec_r;
  logic                             en_r;

  // Control state
  logic [tts_pkg::CNT_W-1:0]  task_count_r, task_count_nxt;
  logic [tts_pkg::CNT_W-1:0]  scan_r, scan_nxt;
  logic                       held_valid_r, held_valid_nxt;
  logic [tts_pkg::ID_W-1:0]   held_id_r, held_id_nxt;
  logic [tts_pkg::FIRE_W-1:0] fire_n_r, fire_n_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Payload registers
  tts_pkg::kind_t           reply_kind_r;
  logic [tts_pkg::ID_W-1:0] reply_id_r;
  tts_pkg::kind_t           out_kind_r, out_kind_nxt;
  logic [tts_pkg::ID_W-1:0] out_id_r, out_id_nxt;
  logic                     out_last_r, out_last_nxt;

  // RAM signals
  logic [tts_pkg::IDX_W-1:0]  ram_addr;
  logic                       ram_wr_en;
  tts_pkg::task_word_t        ram_wr_word;
  logic [tts_pkg::WORD_W-1:0] ram_rd_data;
  tts_pkg::task_word_t        rd_word;

  // Tick evaluation
  logic [tts_pkg::TIMEOUT_BITS-1:0] tmo_dec;
  logic [tts_pkg::RECUR_BITS-1:0]   cnt_inc;
  logic                             fire;
  logic                             emit_ok;
  logic                             tick_push;
  tts_pkg::task_word_t              ev_word;
  tts_pkg::task_word_t              set_word;
  tts_pkg::task_word_t              reg_word;

  logic slot_free;
  logic push_w;

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= tts_pkg::op_t'(in_opcode);
      idx_r <= in_task_index;
      tmo_r <= tts_pkg::TIMEOUT_BITS'(in_new_timeout);
      rec_r <= tts_pkg::RECUR_BITS'(in_recurrence);
      en_r  <= in_enabled;
    end
  end

  // Select the table address
  always_comb begin
    case (cmd.addr_sel)
      tts_pkg::ADDR_SCAN:  ram_addr = scan_r[tts_pkg::IDX_W-1:0];
      tts_pkg::ADDR_IDX:   ram_addr = tts_pkg::IDX_W'(idx_r);
      tts_pkg::ADDR_COUNT: ram_addr = task_count_r[tts_pkg::IDX_W-1:0];
      default:             ram_addr = scan_r[tts_pkg::IDX_W-1:0];
    endcase
  end

  // Evaluate one task entry for a tick
  assign rd_word = tts_pkg::task_word_t'(ram_rd_data);
  assign tmo_dec = (rd_word.timeout != '0) ?
                   (rd_word.timeout - tts_pkg::TIMEOUT_BITS'(1)) : '0;
  assign cnt_inc = rd_word.count + tts_pkg::RECUR_BITS'(1);
  assign fire    = rd_word.en && (tmo_dec == '0) && (rd_word.period != '0) &&
                   (cnt_inc >= rd_word.period);
  assign emit_ok = fire_n_r < tts_pkg::FIRE_W'(tts_pkg::OUT_MAX);

  always_comb begin
    ev_word         = rd_word;
    ev_word.timeout = tmo_dec;
    if (tmo_dec == '0) begin
      if (rd_word.period == '0 || fire) begin
        ev_word.count = '0;
      end else begin
        ev_word.count = cnt_inc;
      end
    end
  end

  // Build the words for set and register
  always_comb begin
    set_word         = rd_word;
    set_word.timeout = tmo_r;
    reg_word.en      = en_r;
    reg_word.period  = rec_r;
    reg_word.count   = '0;
    reg_word.timeout = tmo_r;
  end

  // Write data and enable
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_word = reg_word;
    if (cmd.reg_write) begin
      ram_wr_en   = 1'b1;
      ram_wr_word = reg_word;
    end else if (cmd.set_write) begin
      ram_wr_en   = 1'b1;
      ram_wr_word = set_word;
    end else if (cmd.tick_eval) begin
      ram_wr_en   = rd_word.en;
      ram_wr_word = ev_word;
    end
  end

  tts_ram #(
    .WIDTH (tts_pkg::WORD_W),
    .DEPTH (tts_pkg::MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_addr),
    .wr_data (ram_wr_word),
    .rd_en   (cmd.ram_rd),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  // Output slot and push selection
  assign slot_free = !out_valid_r || out_ready;
  assign tick_push = cmd.tick_eval && fire && emit_ok && held_valid_r;
  assign push_w    = cmd.push_reply || cmd.push_end || tick_push;

  // Count, scan, held item and output register
  always_comb begin
    task_count_nxt = task_count_r;
    scan_nxt       = scan_r;
    held_valid_nxt = held_valid_r;
    held_id_nxt    = held_id_r;
    fire_n_nxt     = fire_n_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;

    if (cmd.reg_write) begin
      task_count_nxt = task_count_r + tts_pkg::CNT_W'(1);
    end

    if (cmd.tick_start) begin
      scan_nxt       = '0;
      held_valid_nxt = 1'b0;
      fire_n_nxt     = '0;
    end else if (cmd.scan_inc) begin
      scan_nxt = scan_r + tts_pkg::CNT_W'(1);
    end

    // a new firing displaces the held one toward the output
    if (cmd.tick_eval && fire && emit_ok) begin
      held_valid_nxt = 1'b1;
      held_id_nxt    = tts_pkg::ID_W'(scan_r);
      fire_n_nxt     = fire_n_r + tts_pkg::FIRE_W'(1);
    end
    if (cmd.push_end) begin
      held_valid_nxt = 1'b0;
    end

    if (push_w) begin
      out_valid_nxt = 1'b1;
      if (cmd.push_reply) begin
        out_kind_nxt = reply_kind_r;
        out_id_nxt   = reply_id_r;
        out_last_nxt = 1'b1;
      end else if (cmd.push_end) begin
        out_kind_nxt = held_valid_r ? tts_pkg::KIND_FIRED : tts_pkg::KIND_NONE;
        out_id_nxt   = held_valid_r ? held_id_r : '0;
        out_last_nxt = 1'b1;
      end else begin
        out_kind_nxt = tts_pkg::KIND_FIRED;
        out_id_nxt   = held_id_r;
        out_last_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
      scan_r       <= '0;
      held_valid_r <= 1'b0;
      fire_n_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      task_count_r <= task_count_nxt;
      scan_r       <= scan_nxt;
      held_valid_r <= held_valid_nxt;
      fire_n_r     <= fire_n_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_id_r  <= held_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  // Capture the single-item reply
  always_ff @(posedge clk) begin
    if (cmd.set_reply) begin
      reply_kind_r <= cmd.reply_kind;
      case (cmd.reply_kind)
        tts_pkg::KIND_REGISTERED: reply_id_r <= tts_pkg::ID_W'(task_count_r);
        tts_pkg::KIND_SET:        reply_id_r <= idx_r;
        tts_pkg::KIND_BAD:        reply_id_r <= idx_r;
        default:                  reply_id_r <= '0;
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    stat.op         = op_r;
    stat.full       = task_count_r == tts_pkg::CNT_W'(tts_pkg::MAX_TASKS);
    stat.idx_ok     = tts_pkg::IDXCMP_W'(idx_r) < tts_pkg::IDXCMP_W'(task_count_r);
    stat.count_zero = task_count_r == '0;
    stat.scan_last  = (scan_r + tts_pkg::CNT_W'(1)) == task_count_r;
    stat.ev_stall   = fire && emit_ok && held_valid_r && !slot_free;
    stat.slot_free  = slot_free;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_task_id = out_id_r;
  assign out_last    = out_last_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    task_count_r <= tts_pkg::CNT_W'(tts_pkg::MAX_TASKS))
    else $error("task count beyond table size");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire_n_r <= tts_pkg::FIRE_W'(tts_pkg::OUT_MAX))
    else $error("fired item count beyond cap");

  a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push_w |-> slot_free)
    else $error("item pushed over an unaccepted result");

  a_end_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_end |=> !held_valid_r)
    else $error("held fired item survived the end of a tick");

  a_reg_increments: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reg_write |=> task_count_r == $past(task_count_r) + tts_pkg::CNT_W'(1))
    else $error("registration did not advance the task count");

endmodule

// ----- rtl/time_triggered_task_scheduler_unit.sv -----
// Top level of the time-triggered task scheduler: controller plus datapath.
// Depends on tts_pkg, tts_in_if, tts_out_if, tts_ctrl and tts_dp.
//
// Usage: requests arrive on in_if (valid/ready), results leave on out_if
// (valid/ready). Opcode 0 is a tick, 1 registers a task, 2 sets a task's
// timeout; opcode 3 is taken and dropped with no result.
// One request is worked at a time; in_if.ready is high only while idle.
// Register and set requests answer with one item. A tick walks the task
// table in index order through one read-modify-write RAM port, reading and
// evaluating each registered task in turn, and then gives its last item.
// Fired items come out in index order; the final item of every request
// has last set, and a tick with no firing gives one "none" item.
// A result register sits on out_if; the block keeps working while a result
// waits, and stalls its table walk only when a second item is ready to go.
// Synchronous active-low reset empties the table (task count zero) and the
// output; the table RAM itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module time_triggered_task_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  tts_in_if.sink     in_if,
  tts_out_if.source  out_if
);

  tts_pkg::ctl_cmd_t cmd;
  tts_pkg::dp_stat_t stat;
  logic              ready_w;

  // Sequence each request
  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (ready_w),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_if.ready = ready_w;

  // Table, evaluation and result register
  tts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_if.opcode),
    .in_task_index  (in_if.task_index),
    .in_new_timeout (in_if.new_timeout),
    .in_recurrence  (in_if.recurrence),
    .in_enabled     (in_if.enabled),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_kind       (out_if.kind),
    .out_task_id    (out_if.task_id),
    .out_last       (out_if.last)
  );

endmodule
